FILE: hw/rtl/distinct_value_counter_macros.svh
// Assertion macros shared by the distinct value counter RTL.
`ifndef DISTINCT_VALUE_COUNTER_MACROS_SVH
`define DISTINCT_VALUE_COUNTER_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define DVC_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define DVC_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/dvc_pkg.sv
// Types, constants and helper functions for the distinct value counter.
package dvc_pkg;

  localparam int KEY_W       = 32;
  localparam int CNT_W       = 12;
  localparam int HB_W        = 4;
  localparam int TABLE_SLOTS = 4096;
  localparam int ADDR_W      = $clog2(TABLE_SLOTS);
  localparam int SLOT_W      = ADDR_W + 1;
  localparam int MIN_BITS    = 8;
  localparam int MAX_BITS    = (ADDR_W > 15) ? 15 : ADDR_W;
  localparam int COUNT_W     = MAX_BITS;
  localparam int EPOCH_W     = 8;
  localparam int SHIFT_W     = 6;

  localparam logic [KEY_W-1:0]   HASH_MULT   = 32'd3141592653;
  localparam logic [KEY_W-1:0]   MISSING_KEY = 32'h8000_0000;
  localparam logic [HB_W-1:0]    HB_RESET    = 4'd12;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              first;
    logic [ADDR_W-1:0] idx;
  } req_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
  } slot_t;

  function automatic logic [HB_W-1:0] eff_bits(input logic [HB_W-1:0] hb);
    logic [HB_W-1:0] k;
    k = hb;
    if (k < HB_W'(MIN_BITS)) k = HB_W'(MIN_BITS);
    if (k > HB_W'(MAX_BITS)) k = HB_W'(MAX_BITS);
    return k;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_mask(input logic [HB_W-1:0] k);
    logic [SLOT_W-1:0] slots;
    slots = SLOT_W'(1) << k;
    return ADDR_W'(slots - 1'b1);
  endfunction

  function automatic logic [COUNT_W-1:0] half_slots(input logic [HB_W-1:0] k);
    logic [SLOT_W-1:0] slots;
    slots = SLOT_W'(1) << k;
    return COUNT_W'(slots >> 1);
  endfunction

endpackage

FILE: hw/rtl/dvc_ifs.sv
// Request and result channel interfaces of the distinct value counter.
interface dvc_in_if;
  import dvc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_value;
  logic                    first_of_set;

  modport source (output valid, key_value, first_of_set, input ready);
  modport sink (input valid, key_value, first_of_set, output ready);
endinterface

interface dvc_out_if;
  import dvc_pkg::*;
  logic             valid;
  logic             ready;
  logic             is_new;
  logic [CNT_W-1:0] distinct_count;
  logic             overflow;

  modport source (output valid, is_new, distinct_count, overflow, input ready);
  modport sink (input valid, is_new, distinct_count, overflow, output ready);
endinterface

FILE: hw/rtl/distinct_value_counter.sv
// Top level of the distinct value counter: hash set with linear probing.
//
//   Channel  Direction  Carries
//   in_chan  sink       key_value, first_of_set
//   out_chan source     is_new, distinct_count, overflow
//   cfg_     write      hash_bits (cfg_we, cfg_wdata)
//
// A request leaves the queue, then reads one slot per probe through the registered
// read port of the slot memory.
// After reset a clearing pass over all 4096 slots runs before the first request is served.
// Every 255th clear of the set (first_of_set or a hash_bits write) runs the same pass.
// A stalled result holds the engine; the front end and queue keep taking requests until they fill.
`include "distinct_value_counter_macros.svh"

module distinct_value_counter (
  input  logic                     clk,
  input  logic                     rst_n,
  dvc_in_if.sink                   in_chan,
  dvc_out_if.source                out_chan,
  input  logic                     cfg_we,
  input  logic [dvc_pkg::HB_W-1:0] cfg_wdata
);
  import dvc_pkg::*;

  logic [HB_W-1:0]    hb_r, hb_nxt;
  logic [HB_W-1:0]    eff_k;
  logic [COUNT_W-1:0] half;
  logic               push_valid, push_ready;
  req_t               push_data;
  logic               q_valid, q_pop;
  req_t               q_data;

  assign hb_nxt = cfg_we ? cfg_wdata : hb_r;
  assign eff_k  = eff_bits(hb_r);
  assign half   = half_slots(eff_k);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r <= HB_RESET;
    end else begin
      hb_r <= hb_nxt;
    end
  end

  dvc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_k     (eff_k),
    .in_chan   (in_chan),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  dvc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  dvc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_k    (eff_k),
    .cfg_clear(cfg_we),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  `DVC_CHECK(a_ovf_is_new, !(out_chan.valid && out_chan.overflow) || out_chan.is_new, "overflow without new key")
  `DVC_IMPLIES(a_count_half, out_chan.valid, COUNT_W'(out_chan.distinct_count) <= half, "count above half the slots")
endmodule

FILE: hw/rtl/dvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: hw/rtl/dvc_front.sv
// Front end: accepts requests, hashes the key and forms the start slot.
module dvc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [dvc_pkg::HB_W-1:0] eff_k,
  dvc_in_if.sink               in_chan,
  output logic                 push_valid,
  input  logic                 push_ready,
  output dvc_pkg::req_t        push_data
);
  import dvc_pkg::*;

  logic                valid_r, valid_nxt;
  logic [KEY_W-1:0]    key_r;
  logic                first_r;
  logic [KEY_W-1:0]    prod_r;
  logic                accept;
  logic [SHIFT_W-1:0]  shamt;
  logic [KEY_W-1:0]    shifted;

  assign in_chan.ready = !valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign valid_nxt     = accept ? 1'b1 : (push_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= $unsigned(in_chan.key_value);
      first_r <= in_chan.first_of_set;
      prod_r  <= HASH_MULT * $unsigned(in_chan.key_value);
    end
  end

  assign shamt   = SHIFT_W'(KEY_W) - SHIFT_W'(eff_k);
  assign shifted = prod_r >> shamt;

  assign push_valid      = valid_r;
  assign push_data.key   = key_r;
  assign push_data.first = first_r;
  assign push_data.idx   = (key_r == MISSING_KEY) ? '0 : shifted[ADDR_W-1:0];
endmodule

FILE: hw/rtl/dvc_queue.sv
// Two-entry queue that decouples the front end from the probe engine.
module dvc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  dvc_pkg::req_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output dvc_pkg::req_t pop_data
);
  import dvc_pkg::*;

  req_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  assign wr_ptr_nxt = wr_ptr_r ^ do_push;
  assign rd_ptr_nxt = rd_ptr_r ^ do_pop;
  assign cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

FILE: hw/rtl/dvc_back.sv
// Probe engine: walks the slot memory, inserts new keys and drives results.
module dvc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [dvc_pkg::HB_W-1:0] eff_k,
  input  logic                     cfg_clear,
  input  logic                     q_valid,
  input  dvc_pkg::req_t            q_data,
  output logic                     q_pop,
  dvc_out_if.source                out_chan
);
  import dvc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SWEEP  = 2'd1;
  localparam logic [1:0] S_PROBE  = 2'd2;
  localparam logic [1:0] S_LOOKUP = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [KEY_W-1:0]   cur_key_r, cur_key_nxt;
  logic [ADDR_W-1:0]  cur_idx_r, cur_idx_nxt;
  logic [ADDR_W-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic               sweep_item_r, sweep_item_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               is_new_r, is_new_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  slot_t              ram_wdata, rd_slot;
  logic [$bits(slot_t)-1:0] ram_rdata;

  logic [ADDR_W-1:0]  mask, next_idx;
  logic [COUNT_W-1:0] half;
  logic               slot_used, key_eq, out_free;

  dvc_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_slot   = slot_t'(ram_rdata);
  assign mask      = slot_mask(eff_k);
  assign half      = half_slots(eff_k);
  assign slot_used = (rd_slot.epoch == epoch_r);
  assign key_eq    = (rd_slot.key == cur_key_r);
  assign next_idx  = (cur_idx_r + 1'b1) & mask;
  assign out_free  = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt      = state_r;
    epoch_nxt      = epoch_r;
    count_nxt      = count_r;
    cur_key_nxt    = cur_key_r;
    cur_idx_nxt    = cur_idx_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_item_nxt = sweep_item_r;
    out_valid_nxt  = out_chan.ready ? 1'b0 : out_valid_r;
    is_new_nxt     = is_new_r;
    ovf_nxt        = ovf_r;
    out_count_nxt  = out_count_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cur_idx_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = cur_idx_r;

    case (state_r)
      S_IDLE: begin
        if (cfg_clear) begin
          count_nxt = '0;
          if (epoch_r == EPOCH_LAST) begin
            state_nxt      = S_SWEEP;
            sweep_addr_nxt = '0;
            sweep_item_nxt = 1'b0;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
          end
        end else if (q_valid) begin
          q_pop       = 1'b1;
          cur_key_nxt = q_data.key;
          cur_idx_nxt = q_data.idx;
          if (q_data.first) begin
            count_nxt = '0;
          end
          if (q_data.first && (epoch_r == EPOCH_LAST)) begin
            state_nxt      = S_SWEEP;
            sweep_addr_nxt = '0;
            sweep_item_nxt = 1'b1;
          end else begin
            if (q_data.first) begin
              epoch_nxt = epoch_r + 1'b1;
            end
            ram_re    = 1'b1;
            ram_raddr = q_data.idx;
            state_nxt = S_PROBE;
          end
        end
      end
      S_SWEEP: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_addr_r;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (cfg_clear) begin
          count_nxt = '0;
        end
        if (sweep_addr_r == ADDR_W'(TABLE_SLOTS - 1)) begin
          epoch_nxt = EPOCH_FIRST;
          if (sweep_item_r) begin
            state_nxt = S_LOOKUP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LOOKUP: begin
        ram_re    = 1'b1;
        ram_raddr = cur_idx_r;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (slot_used && !key_eq) begin
          cur_idx_nxt = next_idx;
          ram_re      = 1'b1;
          ram_raddr   = next_idx;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          is_new_nxt    = !slot_used;
          ovf_nxt       = 1'b0;
          if (!slot_used) begin
            if (count_r >= half) begin
              ovf_nxt = 1'b1;
            end else begin
              ram_we          = 1'b1;
              ram_wdata.epoch = epoch_r;
              ram_wdata.key   = cur_key_r;
              count_nxt       = count_r + 1'b1;
            end
          end
          out_count_nxt = CNT_W'(count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      epoch_r      <= EPOCH_FIRST;
      count_r      <= '0;
      sweep_addr_r <= '0;
      sweep_item_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      count_r      <= count_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_item_r <= sweep_item_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_key_r   <= cur_key_nxt;
    cur_idx_r   <= cur_idx_nxt;
    is_new_r    <= is_new_nxt;
    ovf_r       <= ovf_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.is_new         = is_new_r;
  assign out_chan.overflow       = ovf_r;
  assign out_chan.distinct_count = out_count_r;
endmodule
